/* src/sbg_pkg.sv */
package sbg_pkg;

    // Field widths
    localparam int BAND_W    = 4;
    localparam int HEIGHT_W  = 20;
    localparam int STEP_W    = 16;
    localparam int VEL_W     = 28;
    localparam int GRAV_W    = 24;
    localparam int PPU_W     = 8;
    localparam int ROW_W     = 4;
    localparam int HUE_W     = 8;
    localparam int HUE_CNT_W = 9;

    // Multiplicand width of the serial multiplier (covers velocity)
    localparam int MUL_A_W = VEL_W;

    // Most rows emitted per word
    localparam int MAX_ROWS = 16;

    localparam logic [PPU_W-1:0] PPU_RESET  = 8'd60;
    localparam logic [HUE_W-1:0] BRIGHT_ON  = 8'd255;
    localparam logic [HUE_W-1:0] BRIGHT_OFF = 8'd0;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_GRAVITY = 1'b0,
        CFG_PPU     = 1'b1
    } cfg_idx_t;

    // Control from sequencer to hue generator
    typedef struct packed {
        logic clear;
        logic step;
    } hue_ctrl_t;

endpackage

/* src/spectrum_bar_gravity_renderer.sv */
// From an accepted word, three products (gravity*dt, v*dt, ppu*h) pass in turn
// through one bit-serial multiplier before the first row, then one row a cycle while m_ready allows.
// A new word is accepted only once all min(ROWS,16) rows of the previous one are loaded.
// Reset (aresetn low, synchronous): all held heights and velocities read as zero,
// the hue counter clears, gravity returns to 0 and pixels_per_unit to 60.
module spectrum_bar_gravity_renderer #(
    parameter int BANDS = 16,
    parameter int ROWS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  sbg_pkg::cfg_idx_t             cfg_index,
    input  logic [sbg_pkg::GRAV_W-1:0]    cfg_data,
    // band words in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbg_pkg::BAND_W-1:0]    s_band,
    input  logic [sbg_pkg::HEIGHT_W-1:0]  s_measured_height,
    input  logic [sbg_pkg::STEP_W-1:0]    s_step_time,
    input  logic                          s_idle,
    // pixel words out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbg_pkg::BAND_W-1:0]    m_column,
    output logic [sbg_pkg::ROW_W-1:0]     m_row,
    output logic [sbg_pkg::HUE_W-1:0]     m_hue,
    output logic [sbg_pkg::HUE_W-1:0]     m_brightness,
    output logic                          m_last
);
    import sbg_pkg::*;

    localparam int BIDX  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int BARW  = $clog2(ROWS);
    localparam int NROWS = (ROWS < MAX_ROWS) ? ROWS : MAX_ROWS;
    localparam int WW    = MUL_A_W + 2;

    localparam logic signed [WW-1:0] V_MAX = WW'((1 << (VEL_W - 1)) - 1);
    localparam logic signed [WW-1:0] V_MIN = -WW'(1 << (VEL_W - 1));
    localparam logic signed [WW-1:0] H_MAX = WW'((1 << HEIGHT_W) - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL_G = 5'b00010,
        ST_MUL_V = 5'b00100,
        ST_MUL_B = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [GRAV_W-1:0] gravity_reg;
    logic [PPU_W-1:0]  ppu_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= '0;
            ppu_reg     <= PPU_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_GRAVITY: gravity_reg <= cfg_data;
                CFG_PPU:     ppu_reg     <= cfg_data[PPU_W-1:0];
                default:     ;
            endcase
        end
    end

    // Input accept
    logic            accept;
    logic            in_range;
    logic [BIDX-1:0] s_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = 32'(s_band) < BANDS;
    assign s_idx    = BIDX'(s_band);

    // Latched word
    logic [BAND_W-1:0]   band_reg;
    logic [BIDX-1:0]     idx_reg;
    logic [HEIGHT_W-1:0] meas_reg;
    logic [STEP_W-1:0]   dt_reg;
    logic                idle_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            band_reg <= s_band;
            idx_reg  <= s_idx;
            meas_reg <= s_measured_height;
            dt_reg   <= s_step_time;
            idle_reg <= s_idle;
        end
    end

    // Per-band state memories; entries not yet written read as zero
    logic [HEIGHT_W-1:0]     height_mem [BANDS];
    logic signed [VEL_W-1:0] vel_mem    [BANDS];
    logic [BANDS-1:0]        written_reg;
    logic [HEIGHT_W-1:0]     height_rd_reg;
    logic signed [VEL_W-1:0] vel_rd_reg;
    logic                    rd_ok_reg;
    logic [HEIGHT_W-1:0]     height_old;
    logic signed [VEL_W-1:0] vel_old;
    logic                    mem_we;
    logic [HEIGHT_W-1:0]     height_new;
    logic signed [VEL_W-1:0] vel_new;

    always_ff @(posedge aclk) begin
        if (accept) begin
            height_rd_reg <= height_mem[s_idx];
            vel_rd_reg    <= vel_mem[s_idx];
        end
        if (mem_we) begin
            height_mem[idx_reg] <= height_new;
            vel_mem[idx_reg]    <= vel_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (accept) begin
                rd_ok_reg <= written_reg[s_idx];
            end
            if (mem_we) begin
                written_reg[idx_reg] <= 1'b1;
            end
        end
    end

    assign height_old = rd_ok_reg ? height_rd_reg : '0;
    assign vel_old    = rd_ok_reg ? vel_rd_reg : '0;

    // Shared serial multiplier
    logic                      mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [STEP_W-1:0]         mul_b;
    logic                      mul_done;
    logic signed [MUL_A_W:0]   mul_res;

    sbg_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .done    (mul_done),
        .result  (mul_res)
    );

    // Velocity update: v - floor(gravity*dt / 2^16), saturated
    logic signed [WW-1:0]    v_diff;
    logic signed [VEL_W-1:0] v_sat;
    logic signed [VEL_W-1:0] v_reg;

    always_comb begin
        v_diff = {{2{vel_old[VEL_W-1]}}, vel_old} - {mul_res[MUL_A_W], mul_res};
        if (v_diff < V_MIN) begin
            v_sat = V_MIN[VEL_W-1:0];
        end else if (v_diff > V_MAX) begin
            v_sat = V_MAX[VEL_W-1:0];
        end else begin
            v_sat = v_diff[VEL_W-1:0];
        end
    end

    // Height update: h + floor(v*dt / 2^16), snap up to a higher measurement unless idle, clamp
    logic signed [WW-1:0] h_sum;
    logic signed [WW-1:0] h_sel;
    logic signed [WW-1:0] meas_ext;

    always_comb begin
        h_sum    = signed'(WW'(height_old)) + {mul_res[MUL_A_W], mul_res};
        meas_ext = signed'(WW'(meas_reg));
        h_sel    = h_sum;
        vel_new  = v_reg;
        if (meas_ext > h_sum) begin
            if (!idle_reg) begin
                h_sel = meas_ext;
            end
            vel_new = '0;
        end
        if (h_sel <= 0) begin
            h_sel   = '0;
            vel_new = '0;
        end else if (h_sel > H_MAX) begin
            h_sel = H_MAX;
        end
        height_new = h_sel[HEIGHT_W-1:0];
    end

    // Bar length from floor(ppu*h / 2^16)
    logic [11:0]     bar_raw;
    logic [BARW-1:0] bar_len;
    logic [BARW-1:0] bar_reg;

    always_comb begin
        bar_raw = mul_res[11:0];
        if (bar_raw == 12'd1) begin
            bar_len = '0;
        end else if (32'(bar_raw) >= ROWS) begin
            bar_len = BARW'(ROWS - 1);
        end else begin
            bar_len = BARW'(bar_raw);
        end
    end

    // Row emission
    logic [ROW_W-1:0] row_reg;
    logic             out_load;
    logic             row_lit;
    logic             row_final;
    logic [HUE_W-1:0] hue_val;
    hue_ctrl_t        hue_ctrl;

    assign out_load  = (state_reg == ST_EMIT) && (!m_valid || m_ready);
    assign row_lit   = 32'(row_reg) < 32'(bar_reg);
    assign row_final = 32'(row_reg) == (NROWS - 1);

    assign hue_ctrl.clear = accept && in_range && (s_band == '0);
    assign hue_ctrl.step  = out_load && row_lit;

    sbg_hue_gen #(
        .PIXELS (BANDS * ROWS)
    ) u_hue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (hue_ctrl),
        .hue     (hue_val)
    );

    // Sequencer
    assign mem_we = (state_reg == ST_MUL_V) && mul_done;

    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = signed'(MUL_A_W'(gravity_reg));
        mul_b      = s_step_time;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_range) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_G;
                end
            end
            ST_MUL_G: begin
                mul_a = v_sat;
                mul_b = dt_reg;
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_V;
                end
            end
            ST_MUL_V: begin
                mul_a = signed'(MUL_A_W'(height_new));
                mul_b = STEP_W'(ppu_reg);
                if (mul_done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (mul_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && row_final) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MUL_B && mul_done) begin
                row_reg <= '0;
            end else if (out_load) begin
                row_reg <= row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL_G && mul_done) begin
            v_reg <= v_sat;
        end
        if (state_reg == ST_MUL_B && mul_done) begin
            bar_reg <= bar_len;
        end
    end

    // Output register
    logic             m_valid_reg;
    logic [BAND_W-1:0] m_column_reg;
    logic [ROW_W-1:0] m_row_reg;
    logic [HUE_W-1:0] m_hue_reg;
    logic [HUE_W-1:0] m_bright_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_column_reg <= band_reg;
            m_row_reg    <= row_reg;
            m_hue_reg    <= row_lit ? hue_val : '0;
            m_bright_reg <= row_lit ? BRIGHT_ON : BRIGHT_OFF;
            m_last_reg   <= 32'(row_reg) == (ROWS - 1);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_column     = m_column_reg;
    assign m_row        = m_row_reg;
    assign m_hue        = m_hue_reg;
    assign m_brightness = m_bright_reg;
    assign m_last       = m_last_reg;

endmodule

/* src/sbg_serial_mul.sv */
module sbg_serial_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [sbg_pkg::MUL_A_W-1:0] a_in,
    input  logic        [sbg_pkg::STEP_W-1:0]  b_in,
    output logic                               done,
    output logic signed [sbg_pkg::MUL_A_W:0]   result
);
    import sbg_pkg::*;

    localparam int CNT_W = $clog2(STEP_W);

    logic signed [MUL_A_W-1:0] a_reg;
    logic        [STEP_W-1:0]  b_reg;
    logic signed [MUL_A_W:0]   acc_reg;
    logic signed [MUL_A_W:0]   acc_next;
    logic signed [MUL_A_W+1:0] sum;
    logic        [CNT_W-1:0]   cnt_reg;
    logic                      run_reg;
    logic                      done_reg;

    // One multiplier bit per cycle, LSB first; the accumulator shifts right,
    // so after all bits it holds floor(a*b / 2^STEP_W)
    always_comb begin
        sum = {acc_reg[MUL_A_W], acc_reg}
            + (b_reg[0] ? {{2{a_reg[MUL_A_W-1]}}, a_reg} : '0);
        acc_next = sum[MUL_A_W+1:1];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEP_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end else if (run_reg) begin
            b_reg   <= {1'b0, b_reg[STEP_W-1:1]};
            acc_reg <= acc_next;
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

/* src/sbg_hue_gen.sv */
module sbg_hue_gen #(
    parameter int PIXELS = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sbg_pkg::hue_ctrl_t         ctrl,
    output logic [sbg_pkg::HUE_W-1:0]  hue
);
    import sbg_pkg::*;

    // hue = floor(n*255/PIXELS), tracked as quotient and remainder
    localparam int Q255  = 255 / PIXELS;
    localparam int R255  = 255 % PIXELS;
    localparam int REM_W = $clog2(2 * PIXELS);

    logic [HUE_CNT_W-1:0] cnt_reg;
    logic [HUE_W-1:0]     q_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_sum;

    assign rem_sum = rem_reg + REM_W'(R255);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            cnt_reg <= '0;
            q_reg   <= '0;
            rem_reg <= '0;
        end else if (ctrl.step) begin
            if (cnt_reg == {HUE_CNT_W{1'b1}}) begin
                // counter wraps: back to hue zero
                cnt_reg <= '0;
                q_reg   <= '0;
                rem_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
                if (32'(rem_sum) >= PIXELS) begin
                    rem_reg <= rem_sum - REM_W'(PIXELS);
                    q_reg   <= q_reg + HUE_W'(Q255 + 1);
                end else begin
                    rem_reg <= rem_sum;
                    q_reg   <= q_reg + HUE_W'(Q255);
                end
            end
        end
    end

    assign hue = q_reg;

endmodule
